// File: design/i2c_register_access_master_unit_macros.svh
// ----------------------------------------------------------------------------
// I2C register access master - assertion macros
// Shared property wrappers, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_UNIT_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_UNIT_MACROS_SVH

// same-cycle implication
`define I2CRA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2CRA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/i2cra_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master - package
// Types, codes and helpers shared by the sequencer and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cra_pkg;

    localparam logic [12:0] MAX_TRANSFER = 13'd4096;

    localparam logic [7:0] PHASE_TICKS_RST = 8'd6;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_ACK   = 2'd1;
    localparam logic [1:0] ST_ZERO_LEN = 2'd2;

    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_BYTE_TAIL,
        PH_ACK_SETTLE,
        PH_ACK_HIGH,
        PH_ACK_POLL,
        PH_WAIT_DATA,
        PH_RD_LOW,
        PH_RD_HIGH,
        PH_RACK_LOW,
        PH_RACK_HIGH,
        PH_STOP_A,
        PH_STOP_B
    } t_phase;

    typedef enum logic [2:0] {
        RL_DEV,
        RL_ADDR,
        RL_WDATA,
        RL_RDEV,
        RL_READ,
        RL_FINISH,
        RL_FAIL
    } t_role;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  device_byte;
        logic [23:0] register_address;
        logic [1:0]  address_bytes;
        logic [12:0] byte_count;
        logic        is_read;
        logic [7:0]  write_byte;
        logic        sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       last_byte;
        logic       need_write_byte;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic       read_ack_missed;
    } t_result;

    // address byte still to send, most significant first
    function automatic logic [7:0] addr_sel(input logic [23:0] addr, input logic [1:0] left);
        logic [7:0] b;
        case (left)
            2'd3:    b = addr[23:16];
            2'd2:    b = addr[15:8];
            default: b = addr[7:0];
        endcase
        return b;
    endfunction

endpackage

// File: design/i2cra_core.sv
// ----------------------------------------------------------------------------
// I2C register access master - bus sequencer
// Holds the transfer state and computes one bus step per input item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_register_access_master_unit_macros.svh"

module i2cra_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  i2cra_pkg::t_item   i_item,
    input  logic [7:0]         i_phase_ticks,
    input  logic [7:0]         i_ack_timeout,
    output i2cra_pkg::t_result o_result
);

    i2cra_pkg::t_phase r_phase, n_phase;
    i2cra_pkg::t_role  r_role, n_role;
    logic [8:0]  r_tick, n_tick;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [12:0] r_bytes_left, n_bytes_left;
    logic [1:0]  r_addr_left, n_addr_left;
    logic [23:0] r_saved_addr, n_saved_addr;
    logic [7:0]  r_saved_dev, n_saved_dev;
    logic        r_saved_dir, n_saved_dir;
    logic [7:0]  r_poll, n_poll;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_missed, n_missed;

    logic [7:0]  unit_d;
    logic [7:0]  unit_h;
    logic [8:0]  len_d;
    logic [8:0]  len_h;
    logic [8:0]  len_2d;
    logic [1:0]  addr_dec;
    logic [12:0] bytes_dec;
    logic [12:0] count_sat;
    logic [7:0]  poll_base;
    logic [7:0]  rd_byte;
    logic        rd_valid;
    logic        rd_last;
    logic        done;
    logic [1:0]  status;

    assign unit_d    = (i_phase_ticks == 8'd0) ? 8'd1 : i_phase_ticks;
    assign unit_h    = (unit_d[7:1] == 7'd0) ? 8'd1 : {1'b0, unit_d[7:1]};
    assign len_d     = {1'b0, unit_d};
    assign len_h     = {1'b0, unit_h};
    assign len_2d    = {unit_d, 1'b0};
    assign addr_dec  = (r_addr_left != 2'd0) ? r_addr_left - 2'd1 : 2'd0;
    assign bytes_dec = (r_bytes_left != 13'd0) ? r_bytes_left - 13'd1 : 13'd0;
    assign count_sat = (i_item.byte_count > i2cra_pkg::MAX_TRANSFER) ?
                       i2cra_pkg::MAX_TRANSFER : i_item.byte_count;
    assign poll_base = (r_phase == i2cra_pkg::PH_ACK_HIGH) ? 8'd0 : r_poll;

    always_comb begin
        n_phase      = r_phase;
        n_role       = r_role;
        n_tick       = r_tick;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_addr_left  = r_addr_left;
        n_saved_addr = r_saved_addr;
        n_saved_dev  = r_saved_dev;
        n_saved_dir  = r_saved_dir;
        n_poll       = r_poll;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_missed     = r_missed;
        rd_byte      = 8'd0;
        rd_valid     = 1'b0;
        rd_last      = 1'b0;
        done         = 1'b0;
        status       = i2cra_pkg::ST_OK;

        case (i_item.operation)
            i2cra_pkg::OP_BEGIN: begin
                if (r_phase == i2cra_pkg::PH_IDLE) begin
                    if (i_item.byte_count == 13'd0) begin
                        n_tick = 9'd0;
                        done   = 1'b1;
                        status = i2cra_pkg::ST_ZERO_LEN;
                    end else begin
                        n_saved_dev  = i_item.device_byte;
                        n_saved_addr = i_item.register_address;
                        n_addr_left  = (i_item.address_bytes == 2'd0) ? 2'd1 :
                                       i_item.address_bytes;
                        n_saved_dir  = i_item.is_read;
                        n_bytes_left = count_sat;
                        n_poll       = 8'd0;
                        n_missed     = 1'b0;
                        n_role       = i2cra_pkg::RL_DEV;
                        n_shift      = i_item.device_byte;
                        n_scl        = 1'b1;
                        n_sda        = 1'b1;
                        n_phase      = i2cra_pkg::PH_START_A;
                        n_tick       = len_2d;
                    end
                end
            end
            i2cra_pkg::OP_DATA: begin
                if (r_phase == i2cra_pkg::PH_WAIT_DATA) begin
                    n_shift = i_item.write_byte;
                    n_bit   = 3'd0;
                    n_scl   = 1'b0;
                    n_sda   = i_item.write_byte[7];
                    n_phase = i2cra_pkg::PH_BIT_LOW;
                    n_tick  = len_d;
                end
            end
            i2cra_pkg::OP_TICK: begin
                if (r_phase == i2cra_pkg::PH_IDLE || r_phase == i2cra_pkg::PH_WAIT_DATA) begin
                    n_phase = r_phase;
                end else if (r_phase == i2cra_pkg::PH_ACK_POLL ||
                             (r_phase == i2cra_pkg::PH_ACK_HIGH && r_tick <= 9'd1)) begin
                    n_poll = poll_base;
                    if (!i_item.sda_in) begin
                        n_scl = 1'b0;
                        case (r_role)
                            i2cra_pkg::RL_DEV: begin
                                n_role  = i2cra_pkg::RL_ADDR;
                                n_shift = i2cra_pkg::addr_sel(r_saved_addr, r_addr_left);
                                n_bit   = 3'd0;
                                n_sda   = n_shift[7];
                                n_phase = i2cra_pkg::PH_BIT_LOW;
                                n_tick  = len_d;
                            end
                            i2cra_pkg::RL_ADDR: begin
                                n_addr_left = addr_dec;
                                if (addr_dec != 2'd0) begin
                                    n_shift = i2cra_pkg::addr_sel(r_saved_addr, addr_dec);
                                    n_bit   = 3'd0;
                                    n_sda   = n_shift[7];
                                    n_phase = i2cra_pkg::PH_BIT_LOW;
                                    n_tick  = len_d;
                                end else if (r_saved_dir) begin
                                    n_sda   = 1'b0;
                                    n_phase = i2cra_pkg::PH_STOP_A;
                                    n_tick  = len_2d;
                                end else begin
                                    n_role  = i2cra_pkg::RL_WDATA;
                                    n_phase = i2cra_pkg::PH_WAIT_DATA;
                                    n_tick  = 9'd0;
                                end
                            end
                            i2cra_pkg::RL_WDATA: begin
                                n_bytes_left = bytes_dec;
                                if (bytes_dec != 13'd0) begin
                                    n_phase = i2cra_pkg::PH_WAIT_DATA;
                                    n_tick  = 9'd0;
                                end else begin
                                    n_role  = i2cra_pkg::RL_FINISH;
                                    n_sda   = 1'b0;
                                    n_phase = i2cra_pkg::PH_STOP_A;
                                    n_tick  = len_2d;
                                end
                            end
                            i2cra_pkg::RL_RDEV: begin
                                n_role  = i2cra_pkg::RL_READ;
                                n_bit   = 3'd0;
                                n_shift = 8'd0;
                                n_sda   = 1'b1;
                                n_phase = i2cra_pkg::PH_RD_LOW;
                                n_tick  = len_d;
                            end
                            default: begin
                                n_role  = i2cra_pkg::RL_FINISH;
                                n_sda   = 1'b0;
                                n_phase = i2cra_pkg::PH_STOP_A;
                                n_tick  = len_2d;
                            end
                        endcase
                    end else if (poll_base >= i_ack_timeout) begin
                        if (r_role == i2cra_pkg::RL_RDEV) begin
                            n_missed = 1'b1;
                        end else begin
                            n_role = i2cra_pkg::RL_FAIL;
                        end
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                        n_phase = i2cra_pkg::PH_STOP_A;
                        n_tick  = len_2d;
                    end else begin
                        n_poll  = poll_base + 8'd1;
                        n_phase = i2cra_pkg::PH_ACK_POLL;
                        n_tick  = 9'd0;
                    end
                end else if (r_tick > 9'd1) begin
                    n_tick = r_tick - 9'd1;
                end else begin
                    case (r_phase)
                        i2cra_pkg::PH_START_A: begin
                            n_sda   = 1'b0;
                            n_phase = i2cra_pkg::PH_START_B;
                            n_tick  = len_2d;
                        end
                        i2cra_pkg::PH_START_B: begin
                            n_bit   = 3'd0;
                            n_scl   = 1'b0;
                            n_sda   = r_shift[7];
                            n_phase = i2cra_pkg::PH_BIT_LOW;
                            n_tick  = len_d;
                        end
                        i2cra_pkg::PH_BIT_LOW: begin
                            n_scl   = 1'b1;
                            n_phase = i2cra_pkg::PH_BIT_HIGH;
                            n_tick  = len_d;
                        end
                        i2cra_pkg::PH_BIT_HIGH: begin
                            n_scl = 1'b0;
                            if (r_bit != 3'd7) begin
                                n_bit   = r_bit + 3'd1;
                                n_shift = {r_shift[6:0], 1'b0};
                                n_sda   = r_shift[6];
                                n_phase = i2cra_pkg::PH_BIT_LOW;
                                n_tick  = len_d;
                            end else begin
                                n_phase = i2cra_pkg::PH_BYTE_TAIL;
                                n_tick  = len_d;
                            end
                        end
                        i2cra_pkg::PH_BYTE_TAIL: begin
                            n_sda   = 1'b1;
                            n_phase = i2cra_pkg::PH_ACK_SETTLE;
                            n_tick  = len_h;
                        end
                        i2cra_pkg::PH_ACK_SETTLE: begin
                            n_scl   = 1'b1;
                            n_phase = i2cra_pkg::PH_ACK_HIGH;
                            n_tick  = len_h;
                        end
                        i2cra_pkg::PH_RD_LOW: begin
                            n_scl   = 1'b1;
                            n_shift = {r_shift[6:0], i_item.sda_in};
                            n_phase = i2cra_pkg::PH_RD_HIGH;
                            n_tick  = len_h;
                        end
                        i2cra_pkg::PH_RD_HIGH: begin
                            n_scl = 1'b0;
                            if (r_bit != 3'd7) begin
                                n_bit   = r_bit + 3'd1;
                                n_phase = i2cra_pkg::PH_RD_LOW;
                                n_tick  = len_d;
                            end else begin
                                rd_valid = 1'b1;
                                rd_byte  = r_shift;
                                rd_last  = (r_bytes_left <= 13'd1);
                                n_sda    = rd_last;
                                n_phase  = i2cra_pkg::PH_RACK_LOW;
                                n_tick   = len_d;
                            end
                        end
                        i2cra_pkg::PH_RACK_LOW: begin
                            n_scl   = 1'b1;
                            n_phase = i2cra_pkg::PH_RACK_HIGH;
                            n_tick  = len_d;
                        end
                        i2cra_pkg::PH_RACK_HIGH: begin
                            n_scl        = 1'b0;
                            n_bytes_left = bytes_dec;
                            if (bytes_dec != 13'd0) begin
                                n_bit   = 3'd0;
                                n_shift = 8'd0;
                                n_sda   = 1'b1;
                                n_phase = i2cra_pkg::PH_RD_LOW;
                                n_tick  = len_d;
                            end else begin
                                n_role  = i2cra_pkg::RL_FINISH;
                                n_sda   = 1'b0;
                                n_phase = i2cra_pkg::PH_STOP_A;
                                n_tick  = len_2d;
                            end
                        end
                        i2cra_pkg::PH_STOP_A: begin
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                            n_phase = i2cra_pkg::PH_STOP_B;
                            n_tick  = len_2d;
                        end
                        i2cra_pkg::PH_STOP_B: begin
                            if (r_role == i2cra_pkg::RL_ADDR) begin
                                n_role  = i2cra_pkg::RL_RDEV;
                                n_shift = r_saved_dev | 8'h01;
                                n_scl   = 1'b1;
                                n_sda   = 1'b1;
                                n_phase = i2cra_pkg::PH_START_A;
                                n_tick  = len_2d;
                            end else if (r_role == i2cra_pkg::RL_RDEV) begin
                                n_role  = i2cra_pkg::RL_READ;
                                n_bit   = 3'd0;
                                n_shift = 8'd0;
                                n_scl   = 1'b0;
                                n_sda   = 1'b1;
                                n_phase = i2cra_pkg::PH_RD_LOW;
                                n_tick  = len_d;
                            end else begin
                                n_phase = i2cra_pkg::PH_IDLE;
                                n_tick  = 9'd0;
                                done    = 1'b1;
                                status  = (r_role == i2cra_pkg::RL_FAIL) ?
                                          i2cra_pkg::ST_NO_ACK : i2cra_pkg::ST_OK;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_comb begin
        o_result.scl_level       = n_scl;
        o_result.sda_level       = n_sda;
        o_result.read_byte       = rd_byte;
        o_result.read_valid      = rd_valid;
        o_result.last_byte       = rd_last;
        o_result.need_write_byte = (n_phase == i2cra_pkg::PH_WAIT_DATA);
        o_result.busy_res        = (n_phase != i2cra_pkg::PH_IDLE);
        o_result.done_res        = done;
        o_result.status          = status;
        o_result.read_ack_missed = n_missed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cra_pkg::PH_IDLE;
            r_role       <= i2cra_pkg::RL_DEV;
            r_tick       <= 9'd0;
            r_bit        <= 3'd0;
            r_shift      <= 8'd0;
            r_bytes_left <= 13'd0;
            r_addr_left  <= 2'd0;
            r_saved_addr <= 24'd0;
            r_saved_dev  <= 8'd0;
            r_saved_dir  <= 1'b0;
            r_poll       <= 8'd0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_missed     <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_role       <= n_role;
            r_tick       <= n_tick;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_bytes_left <= n_bytes_left;
            r_addr_left  <= n_addr_left;
            r_saved_addr <= n_saved_addr;
            r_saved_dev  <= n_saved_dev;
            r_saved_dir  <= n_saved_dir;
            r_poll       <= n_poll;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_missed     <= n_missed;
        end
    end

    `I2CRA_ASSERT_IMP(a_idle_lines_released, r_phase == i2cra_pkg::PH_IDLE, r_scl && r_sda, "lines not released while idle")
    `I2CRA_ASSERT_IMP(a_wait_scl_low, r_phase == i2cra_pkg::PH_WAIT_DATA, !r_scl, "SCL released while waiting for write data")
    `I2CRA_ASSERT_NXT(a_data_starts_byte, i_rst_n && i_step && i_item.operation == i2cra_pkg::OP_DATA && r_phase == i2cra_pkg::PH_WAIT_DATA, r_phase == i2cra_pkg::PH_BIT_LOW && r_bit == 3'd0, "write byte not started")
    `I2CRA_ASSERT_NXT(a_busy_begin_ignored, i_rst_n && i_step && i_item.operation == i2cra_pkg::OP_BEGIN && r_phase != i2cra_pkg::PH_IDLE, $stable(r_saved_dev) && $stable(r_bytes_left), "begin taken while busy")

endmodule

// File: design/i2c_register_access_master_unit.sv
// Each input transfer passes through the input register and then the result register.
// Throughput: one input item per cycle unless the output stalls; one result item per input item.
// The bus sequencer steps once per item, so the input register stalls only on output backpressure.
// Reset (i_rst_n low at a clock edge): sequencer idle, SCL/SDA released,
// both stages empty, phase_ticks = 6 and ack_timeout = 250.
// ----------------------------------------------------------------------------
// I2C register access master - top level
// Input register, bus sequencer, result register and configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_register_access_master_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_device_byte,
    input  logic [23:0] i_register_address,
    input  logic [1:0]  i_address_bytes,
    input  logic [12:0] i_byte_count,
    input  logic        i_is_read,
    input  logic [7:0]  i_write_byte,
    input  logic        i_sda_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic [7:0]  o_read_byte,
    output logic        o_read_valid,
    output logic        o_last_byte,
    output logic        o_need_write_byte,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    output logic        o_read_ack_missed,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic               r_in_valid;
    i2cra_pkg::t_item   r_in;
    logic               r_out_valid;
    i2cra_pkg::t_result r_out;
    logic [7:0]         r_phase_ticks;
    logic [7:0]         r_ack_timeout;

    logic               out_free;
    logic               step;
    i2cra_pkg::t_item   in_item;
    i2cra_pkg::t_result step_res;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_comb begin
        in_item.operation        = i_operation;
        in_item.device_byte      = i_device_byte;
        in_item.register_address = i_register_address;
        in_item.address_bytes    = i_address_bytes;
        in_item.byte_count       = i_byte_count;
        in_item.is_read          = i_is_read;
        in_item.write_byte       = i_write_byte;
        in_item.sda_in           = i_sda_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= in_item;
        end
    end

    i2cra_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (r_in),
        .i_phase_ticks (r_phase_ticks),
        .i_ack_timeout (r_ack_timeout),
        .o_result      (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cra_pkg::PHASE_TICKS_RST;
            r_ack_timeout <= i2cra_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                i2cra_pkg::CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_data;
                i2cra_pkg::CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data;
                default:                    r_phase_ticks <= r_phase_ticks;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_scl_level       = r_out.scl_level;
    assign o_sda_level       = r_out.sda_level;
    assign o_read_byte       = r_out.read_byte;
    assign o_read_valid      = r_out.read_valid;
    assign o_last_byte       = r_out.last_byte;
    assign o_need_write_byte = r_out.need_write_byte;
    assign o_busy_res        = r_out.busy_res;
    assign o_done_res        = r_out.done_res;
    assign o_status          = r_out.status;
    assign o_read_ack_missed = r_out.read_ack_missed;

endmodule
